[design/gls_pkg.sv]
// shared types and constants of the grid laplacian stencil
`default_nettype none

package gls_pkg;

    localparam int HEIGHT_BITS   = 16;
    localparam int LAP_BITS      = HEIGHT_BITS + 3;
    localparam int ROWS_BITS     = 16;
    localparam int COLS_BITS     = 11;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [ROWS_BITS-1:0] ROWS_RESET = ROWS_BITS'(1024);
    localparam logic [COLS_BITS-1:0] COLS_RESET = COLS_BITS'(1024);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_ROWS_USED = 2'd0,
        REG_COLS_USED = 2'd1
    } cfg_reg_t;

    typedef logic signed [HEIGHT_BITS-1:0] height_t;
    typedef logic signed [LAP_BITS-1:0]    lap_t;

    // neighbours of the point in flight inside the grid, frame end, bank of its up row
    typedef struct packed {
        logic has_up;
        logic has_left;
        logic has_right;
        logic has_down;
        logic last;
        logic up_bank;
    } nbr_flags_t;

endpackage

`default_nettype wire

[design/gls_if.sv]
// stream and configuration channel interfaces of the grid laplacian stencil
`default_nettype none

interface gls_sample_if import gls_pkg::*; ();
    logic    valid;
    logic    ready;
    logic    drain;
    height_t height;

    modport source (output valid, output drain, output height, input ready);
    modport sink   (input valid, input drain, input height, output ready);
endinterface

interface gls_result_if import gls_pkg::*; ();
    logic valid;
    logic ready;
    lap_t laplacian;
    logic last_point;

    modport source (output valid, output laplacian, output last_point, input ready);
    modport sink   (input valid, input laplacian, input last_point, output ready);
endinterface

interface gls_cfg_if import gls_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[design/grid_laplacian_stencil_top.sv]
// grid laplacian stencil: streaming five-point laplacian over a raster height grid
//
// samples: raster heights, rows_used rows of cols_used points, then cols_used
//   drain items that flush the final row. a sample after all rows are in, or a
//   drain item before that, is taken and dropped.
// results: one laplacian per grid point, in raster order, from the second row's
//   samples on; last_point marks the final point of the frame.
// cfg: register writes (index 0 rows_used, index 1 cols_used), always ready,
//   only to be issued while the block is idle.
// a transfer passes the stage in flight, then the output register; one item per
//   cycle is sustained unless results stalls. the two line-store banks each give
//   two registered reads per cycle, so every sample and drain item takes one pass.
// when results stalls, the output register holds, then the stage in flight,
//   and samples.ready drops only once both are full.
// reset clears the counters, registers back to 1024 x 1024; the line stores
//   are not cleared and need no pass after reset.
`default_nettype none

module grid_laplacian_stencil_top
    import gls_pkg::*;
#(
    parameter int MAX_COLS = 1024
)
(
    input  wire          clk,
    input  wire          rst_n,
    gls_sample_if.sink   samples,
    gls_result_if.source results,
    gls_cfg_if.sink      cfg
);

    localparam int CW   = $clog2(MAX_COLS);
    localparam int NC_W = (CW + 1 > COLS_BITS) ? CW + 1 : COLS_BITS;

    // configuration
    logic [ROWS_BITS-1:0] rows_used_reg;
    logic [COLS_BITS-1:0] cols_used_reg;

    // scan position
    logic [ROWS_BITS-1:0] row_count_reg, row_count_next;
    logic [CW-1:0]        col_count_reg, col_count_next;

    // line stores, one bank per row parity
    height_t mem0 [MAX_COLS];
    height_t mem1 [MAX_COLS];
    height_t b0a_reg, b0b_reg, b1a_reg, b1b_reg;

    // stage in flight
    logic       s1_valid_reg;
    nbr_flags_t s1_flags_reg;
    height_t    s1_down_reg;
    height_t    left_reg;

    // output register
    logic out_valid_reg;
    lap_t lap_reg;
    logic last_reg;

    logic [ROWS_BITS-1:0] nrows;
    logic [NC_W-1:0]      ncols;
    logic                 col_last;
    logic [CW-1:0]        rd_right;
    logic                 s1_go, in_ready, acc;
    logic                 take_sample, take_drain, produce;
    logic                 wr_en0, wr_en1, rd_en;
    nbr_flags_t           flags;

    height_t centre, up_val, right_val;
    lap_t    sum, centre_ext, n_ext, lap_val;
    logic [2:0] n_cnt;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_used_reg <= ROWS_RESET;
            cols_used_reg <= COLS_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_ROWS_USED: rows_used_reg <= cfg.data[ROWS_BITS-1:0];
                REG_COLS_USED: cols_used_reg <= cfg.data[COLS_BITS-1:0];
                default:       ;
            endcase
        end
    end

    // effective grid size, out-of-range values clamped
    always_comb
    begin
        nrows = (rows_used_reg == '0) ? ROWS_BITS'(1) : rows_used_reg;
        if (cols_used_reg == '0)
            ncols = NC_W'(1);
        else if (NC_W'(cols_used_reg) > NC_W'(MAX_COLS))
            ncols = NC_W'(MAX_COLS);
        else
            ncols = NC_W'(cols_used_reg);
    end

    assign col_last = (NC_W'(col_count_reg) + NC_W'(1)) >= ncols;
    assign rd_right = (col_count_reg == CW'(MAX_COLS - 1)) ? '0 : col_count_reg + CW'(1);

    assign s1_go    = !out_valid_reg || results.ready;
    assign in_ready = !s1_valid_reg || s1_go;
    assign acc      = samples.valid && in_ready;
    assign samples.ready = in_ready;

    assign take_sample = !samples.drain && (row_count_reg < nrows);
    assign take_drain  = samples.drain && (row_count_reg >= nrows);
    assign produce     = (take_sample && (row_count_reg != '0)) || take_drain;

    assign wr_en0 = acc && take_sample && !row_count_reg[0];
    assign wr_en1 = acc && take_sample && row_count_reg[0];
    assign rd_en  = acc && produce;

    always_comb
    begin
        flags.has_up    = row_count_reg >= ROWS_BITS'(2);
        flags.has_left  = col_count_reg != '0;
        flags.has_right = !col_last;
        flags.has_down  = !samples.drain;
        flags.last      = samples.drain && col_last;
        flags.up_bank   = row_count_reg[0];
    end

    always_comb
    begin
        row_count_next = row_count_reg;
        col_count_next = col_count_reg;
        if (acc && take_sample)
        begin
            if (col_last)
            begin
                col_count_next = '0;
                row_count_next = row_count_reg + ROWS_BITS'(1);
            end
            else
            begin
                col_count_next = col_count_reg + CW'(1);
            end
        end
        else if (acc && take_drain)
        begin
            if (col_last)
            begin
                col_count_next = '0;
                row_count_next = '0;
            end
            else
            begin
                col_count_next = col_count_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= '0;
            col_count_reg <= '0;
        end
        else
        begin
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
        end
    end

    // read before write: the up neighbour sits where the new sample lands
    always_ff @(posedge clk)
    begin
        if (wr_en0)
            mem0[col_count_reg] <= samples.height;
        if (rd_en)
        begin
            b0a_reg <= mem0[col_count_reg];
            b0b_reg <= mem0[rd_right];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en1)
            mem1[col_count_reg] <= samples.height;
        if (rd_en)
        begin
            b1a_reg <= mem1[col_count_reg];
            b1b_reg <= mem1[rd_right];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= acc && produce;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            s1_flags_reg <= flags;
            s1_down_reg  <= samples.height;
        end
        // centre of this point is the left neighbour of the next one
        if (s1_valid_reg && s1_go)
            left_reg <= centre;
    end

    always_comb
    begin
        centre    = s1_flags_reg.up_bank ? b0a_reg : b1a_reg;
        up_val    = s1_flags_reg.up_bank ? b1a_reg : b0a_reg;
        right_val = s1_flags_reg.up_bank ? b0b_reg : b1b_reg;

        n_cnt = 3'(s1_flags_reg.has_up) + 3'(s1_flags_reg.has_left)
              + 3'(s1_flags_reg.has_right) + 3'(s1_flags_reg.has_down);

        sum = (s1_flags_reg.has_up    ? LAP_BITS'(up_val)      : '0)
            + (s1_flags_reg.has_left  ? LAP_BITS'(left_reg)    : '0)
            + (s1_flags_reg.has_right ? LAP_BITS'(right_val)   : '0)
            + (s1_flags_reg.has_down  ? LAP_BITS'(s1_down_reg) : '0);

        centre_ext = LAP_BITS'(centre);
        n_ext      = {{(LAP_BITS-3){1'b0}}, n_cnt};
        lap_val    = sum - LAP_BITS'(centre_ext * n_ext);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_go)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_valid_reg)
        begin
            lap_reg  <= lap_val;
            last_reg <= s1_flags_reg.last;
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.laplacian  = lap_reg;
    assign results.last_point = last_reg;

endmodule

`default_nettype wire

[tb/tb_top.sv]
// self-checking testbench of the grid laplacian stencil: raster frames, extremes, idling
module tb_top;
    import gls_pkg::*;

    localparam int MAX_COLS    = 1024;
    localparam int TAIL_CYCLES = 8;
    localparam int SETTLE_CAP  = 20000;
    localparam int HOLD_CYCLES = 300;
    localparam int RUN_LIMIT   = 400000;

    localparam height_t H_MIN = {1'b1, {(HEIGHT_BITS-1){1'b0}}};
    localparam height_t H_MAX = ~H_MIN;

    typedef struct packed {
        logic    drain;
        height_t height;
    } grid_item_t;

    typedef struct {
        lap_t lap;
        logic last;
    } lap_expect_t;

    logic clk;
    logic rst_n;

    gls_sample_if samples_if();
    gls_result_if results_if();
    gls_cfg_if    cfg_if();

    grid_laplacian_stencil_top #(.MAX_COLS(MAX_COLS)) dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_if),
        .results (results_if),
        .cfg     (cfg_if)
    );

    // stimulus and expectations
    grid_item_t  feed_q[$];
    lap_expect_t lap_expect_q[$];

    // predictor state
    height_t        line_banks[2*MAX_COLS];
    logic [15:0]    rows_reg;
    logic [10:0]    cols_reg;
    int unsigned    row_at;
    int unsigned    col_at;
    height_t        down_hgt;

    int  items_queued;
    int  items_taken;
    int  items_counted;
    int  dropped_sent;
    int  points_checked;
    int  frames_seen;
    int  errors;
    int  gap_pct;
    int  stall_pct;
    bit  hold_req;
    logic rx_hold;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        rst_n              = 1'b0;
        samples_if.valid   = 1'b0;
        samples_if.drain   = 1'b0;
        samples_if.height  = '0;
        results_if.ready   = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = REG_ROWS_USED;
        cfg_if.data        = '0;
        rx_hold            = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #(RUN_LIMIT * 8);
        $display("timeout after %0d cycles", RUN_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    function automatic int unsigned rows_eff();
        return (rows_reg == 0) ? 1 : rows_reg;
    endfunction

    function automatic int unsigned cols_eff();
        if (cols_reg == 0)
            return 1;
        if (cols_reg > MAX_COLS)
            return MAX_COLS;
        return cols_reg;
    endfunction

    // laplacian of a stored point; the down neighbour comes with the sample below
    function automatic int five_point(int unsigned row, int unsigned col, int unsigned ncols,
                                      bit has_down, int down);
        int base;
        int up_base;
        int ctr;
        int acc;
        int n;
        base    = (row % 2) * MAX_COLS;
        up_base = ((row + 1) % 2) * MAX_COLS;
        ctr     = line_banks[base + col];
        acc     = 0;
        n       = 0;
        if (row >= 1)
        begin
            acc += line_banks[up_base + col];
            n++;
        end
        if (col >= 1)
        begin
            acc += line_banks[base + col - 1];
            n++;
        end
        if (has_down)
        begin
            acc += down;
            n++;
        end
        if (col + 1 < ncols)
        begin
            acc += line_banks[base + col + 1];
            n++;
        end
        return acc - n * ctr;
    endfunction

    function automatic void step_laplacian(logic drain, height_t hgt);
        int unsigned nrows;
        int unsigned ncols;
        int unsigned col;
        lap_expect_t e;
        nrows = rows_eff();
        ncols = cols_eff();
        col   = (col_at >= MAX_COLS) ? MAX_COLS - 1 : col_at;
        if (!drain)
        begin
            // samples beyond the last row are dropped
            if (row_at >= nrows)
                return;
            down_hgt = hgt;
            if (row_at >= 1)
            begin
                e.lap  = lap_t'(five_point(row_at - 1, col, ncols, 1'b1, down_hgt));
                e.last = 1'b0;
                lap_expect_q = {lap_expect_q, e};
            end
            line_banks[(row_at % 2) * MAX_COLS + col] = hgt;
            if (col_at + 1 >= ncols)
            begin
                col_at = 0;
                row_at++;
            end
            else
                col_at++;
        end
        else
        begin
            // drain items before the last row is in are dropped
            if (row_at < nrows)
                return;
            e.lap  = lap_t'(five_point(row_at - 1, col, ncols, 1'b0, 0));
            e.last = (col + 1 >= ncols);
            lap_expect_q = {lap_expect_q, e};
            if (e.last)
            begin
                col_at = 0;
                row_at = 0;
            end
            else
                col_at = col + 1;
        end
    endfunction

    // sample driver
    always @(posedge clk)
    begin : feed_drv
        grid_item_t nxt;
        if (!rst_n)
            samples_if.valid <= 1'b0;
        else
        begin
            if (samples_if.valid && samples_if.ready)
            begin
                step_laplacian(samples_if.drain, samples_if.height);
                items_taken++;
            end
            if (!samples_if.valid || samples_if.ready)
            begin
                if (feed_q.size() != 0 && $urandom_range(99) >= gap_pct)
                begin
                    nxt = feed_q.pop_front();
                    samples_if.valid  <= 1'b1;
                    samples_if.drain  <= nxt.drain;
                    samples_if.height <= nxt.height;
                end
                else
                    samples_if.valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin : lap_mon
        lap_expect_t want;
        if (!rst_n)
            results_if.ready <= 1'b0;
        else
        begin
            if (results_if.valid && results_if.ready)
            begin
                if (lap_expect_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result: lap %0d last %0b",
                                 results_if.laplacian, results_if.last_point);
                end
                else
                begin
                    want = lap_expect_q.pop_front();
                    points_checked++;
                    if (want.last)
                        frames_seen++;
                    if (results_if.laplacian !== want.lap || results_if.last_point !== want.last)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("point %0d: expected lap %0d last %0b, got lap %0d last %0b",
                                     points_checked, want.lap, want.last,
                                     results_if.laplacian, results_if.last_point);
                    end
                end
            end
            results_if.ready <= !rx_hold && ($urandom_range(99) >= stall_pct);
        end
    end

    // long receiver hold-off so the block fills and backs up its input
    initial
    begin
        wait (hold_req);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    function automatic height_t pick_height();
        case ($urandom_range(7))
            0: return H_MIN;
            1: return H_MAX;
            2: return height_t'(int'($urandom_range(8)) - 4);
            default: return height_t'($urandom);
        endcase
    endfunction

    function automatic void push_item(logic drain, height_t hgt, bit counted);
        grid_item_t it;
        it.drain  = drain;
        it.height = hgt;
        feed_q = {feed_q, it};
        items_queued++;
        if (counted)
            items_counted++;
        else
            dropped_sent++;
    endfunction

    // pattern 0 random, 1 and 2 checkerboards of opposite polarity
    function automatic void queue_frame(int unsigned nrows, int unsigned ncols, int pattern,
                                        bit noisy);
        int unsigned r;
        int unsigned c;
        int unsigned early_at;
        bit put_early;
        height_t h;
        put_early = noisy && ($urandom_range(1) == 0);
        early_at  = $urandom_range(nrows * ncols - 1);
        for (r = 0; r < nrows; r++)
            for (c = 0; c < ncols; c++)
            begin
                if (put_early && r * ncols + c == early_at)
                    push_item(1'b1, pick_height(), 1'b0);
                if (pattern == 0)
                    h = pick_height();
                else
                    h = (((r + c) % 2) == pattern - 1) ? H_MIN : H_MAX;
                push_item(1'b0, h, 1'b1);
            end
        if (noisy)
            repeat ($urandom_range(2, 1)) push_item(1'b0, pick_height(), 1'b0);
        for (c = 0; c < ncols; c++)
            push_item(1'b1, pick_height(), 1'b1);
    endfunction

    // wait until every item is taken and every result is in, then let the pipe empty
    task automatic settle();
        int n;
        n = 0;
        do
        begin
            @(negedge clk);
            n++;
        end
        while ((items_taken != items_queued || lap_expect_q.size() != 0) && n < SETTLE_CAP);
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] val);
        @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        if (idx == REG_ROWS_USED)
            rows_reg = val;
        else if (idx == REG_COLS_USED)
            cols_reg = val[10:0];
    endtask

    task automatic run_grid(logic [15:0] rows_val, logic [15:0] cols_val, int frames);
        int k;
        settle();
        write_reg(REG_ROWS_USED, rows_val);
        write_reg(REG_COLS_USED, cols_val);
        for (k = 0; k < frames; k++)
            queue_frame(rows_eff(), cols_eff(),
                        ($urandom_range(9) == 0) ? int'($urandom_range(2, 1)) : 0,
                        $urandom_range(5) == 0);
    endtask

    task automatic random_phase(int gap, int stall, int target);
        int start;
        int unsigned nr;
        int unsigned nc;
        settle();
        gap_pct   = gap;
        stall_pct = stall;
        start     = items_counted;
        while (items_counted - start < target)
        begin
            nr = ($urandom_range(4) == 0) ? $urandom_range(10, 6) : $urandom_range(5, 1);
            nc = ($urandom_range(3) == 0) ? $urandom_range(24, 9) : $urandom_range(8, 1);
            run_grid(16'(nr), 16'(nc), $urandom_range(2, 1));
        end
    endtask

    initial
    begin
        items_queued   = 0;
        items_taken    = 0;
        items_counted  = 0;
        dropped_sent   = 0;
        points_checked = 0;
        frames_seen    = 0;
        errors         = 0;
        gap_pct        = 0;
        stall_pct      = 0;
        hold_req       = 1'b0;
        rows_reg       = ROWS_RESET;
        cols_reg       = COLS_RESET;
        row_at         = 0;
        col_at         = 0;
        down_hgt       = '0;
        wait (rst_n);

        // single point: early drain and late sample are both dropped
        settle();
        write_reg(REG_ROWS_USED, 16'd1);
        write_reg(REG_COLS_USED, 16'd1);
        push_item(1'b1, H_MAX, 1'b0);
        push_item(1'b0, H_MIN, 1'b1);
        push_item(1'b0, H_MAX, 1'b0);
        push_item(1'b1, H_MIN, 1'b1);

        // checkerboard of extreme heights, interior point hits the top of the range
        settle();
        write_reg(REG_ROWS_USED, 16'd3);
        write_reg(REG_COLS_USED, 16'd3);
        queue_frame(3, 3, 1, 1'b0);

        // zero in both registers behaves as one
        run_grid(16'd0, 16'd0, 1);

        // row width shrinks partway through the first row
        settle();
        write_reg(REG_ROWS_USED, 16'd3);
        write_reg(REG_COLS_USED, 16'd8);
        repeat (5) push_item(1'b0, pick_height(), 1'b1);
        settle();
        // upper data bits lie outside the column register
        write_reg(REG_COLS_USED, 16'hF804);
        repeat (9) push_item(1'b0, pick_height(), 1'b1);
        repeat (4) push_item(1'b1, pick_height(), 1'b1);

        // full row count, then cut the frame short once four rows are in
        settle();
        write_reg(REG_ROWS_USED, 16'hFFFF);
        write_reg(REG_COLS_USED, 16'd3);
        repeat (12) push_item(1'b0, pick_height(), 1'b1);
        push_item(1'b1, pick_height(), 1'b0);
        settle();
        write_reg(REG_ROWS_USED, 16'd4);
        repeat (3) push_item(1'b1, pick_height(), 1'b1);

        // column register above the store width, then narrowed mid row
        settle();
        write_reg(REG_ROWS_USED, 16'd2);
        write_reg(REG_COLS_USED, 16'd2047);
        repeat (6) push_item(1'b0, pick_height(), 1'b1);
        settle();
        write_reg(REG_COLS_USED, 16'd3);
        repeat (4) push_item(1'b0, pick_height(), 1'b1);
        repeat (3) push_item(1'b1, pick_height(), 1'b1);

        // receiver holds off while the sender keeps streaming
        settle();
        write_reg(REG_ROWS_USED, 16'd6);
        write_reg(REG_COLS_USED, 16'd20);
        hold_req = 1'b1;
        queue_frame(6, 20, 0, 1'b0);

        random_phase(0, 0, 90);
        random_phase(85, 0, 90);
        random_phase(0, 85, 90);
        random_phase(38, 38, 90);
        settle();

        if (lap_expect_q.size() != 0)
        begin
            errors += lap_expect_q.size();
            $display("%0d expected results never arrived", lap_expect_q.size());
        end
        $display("checked %0d laplacian points over %0d frames, %0d dropped items sent",
                 points_checked, frames_seen, dropped_sent);
        $display("register extremes, mid-frame changes, input back-pressure and idling mixes");
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
